// ===== hw/rtl/wavhfx_pkg.sv =====
package wavhfx_pkg;

  // Width of the byte position counter; it saturates at all ones.
  localparam int unsigned PosW = 32;

  localparam int unsigned RateW  = 32;
  localparam int unsigned TotalW = 35;
  localparam int unsigned QuoW   = 51;

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t PosMax = {PosW{1'b1}};

  localparam logic [15:0] DefChannels = 16'd2;
  localparam logic [31:0] DefRate     = 32'd44100;
  localparam logic [15:0] DefBits     = 16'd16;

  localparam logic [31:0] RiffMark = 32'h52494646;  // "RIFF"
  localparam logic [31:0] WaveMark = 32'h57415645;  // "WAVE"
  localparam logic [31:0] TagFmt   = 32'h666D7420;  // "fmt "
  localparam logic [31:0] TagData  = 32'h64617461;  // "data"

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                header_ok;
    logic                format_taken;
    logic [15:0]         channel_count;
    logic [RateW-1:0]    sample_rate;
    logic [15:0]         bits_per_sample;
    logic [31:0]         data_offset;
    logic [31:0]         data_size;
    logic [TotalW-1:0]   total_samples;
    logic [QuoW-1:0]     duration_q16;
  } out_t;

  // Header fields as seen once the last byte has been scanned.
  typedef struct packed {
    logic        ok;
    logic        taken;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] off;
    logic [31:0] size;
  } scan_sum_t;

  // Byte idx of a four-character marker, first character at idx 0.
  function automatic logic [7:0] mark_byte(logic [31:0] mark, logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = mark[31:24];
      2'd1:    b = mark[23:16];
      2'd2:    b = mark[15:8];
      default: b = mark[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/wavhfx_scanner.sv =====
module wavhfx_scanner (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic                   clear_i,
  input  logic [7:0]             byte_i,
  output wavhfx_pkg::scan_sum_t  sum_o
);

  // Offsets from the start of a tag; the counters hold the offset of the next byte.
  localparam logic [4:0] FmtFirst = 5'd4;
  localparam logic [4:0] FmtSpan  = 5'd24;
  localparam logic [4:0] RelCh0   = 5'd10;
  localparam logic [4:0] RelCh1   = 5'd11;
  localparam logic [4:0] RelRate0 = 5'd12;
  localparam logic [4:0] RelRate1 = 5'd13;
  localparam logic [4:0] RelRate2 = 5'd14;
  localparam logic [4:0] RelRate3 = 5'd15;
  localparam logic [4:0] RelBits0 = 5'd22;
  localparam logic [4:0] RelBits1 = 5'd23;
  localparam logic [3:0] DataFirst = 4'd4;
  localparam logic [3:0] RelSize0  = 4'd4;
  localparam logic [3:0] RelSize1  = 4'd5;
  localparam logic [3:0] RelSize2  = 4'd6;
  localparam logic [3:0] RelSize3  = 4'd7;
  localparam logic [3:0] DataDone  = 4'd9;

  wavhfx_pkg::pos_t pos_q, pos_d;
  logic [31:0] window_q, window_d;
  logic        marker_q, marker_d;
  logic [4:0]  fmt_rel_q, fmt_rel_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [3:0]  data_rel_q, data_rel_d;
  logic [31:0] off_q, off_d;
  logic [31:0] size_q, size_d;

  logic        take;
  logic [31:0] win;

  assign take = take_i && (pos_q != wavhfx_pkg::PosMax);
  assign win  = {window_q[23:0], byte_i};

  always_comb begin
    pos_d      = pos_q;
    window_d   = window_q;
    marker_d   = marker_q;
    fmt_rel_d  = fmt_rel_q;
    ch_d       = ch_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    data_rel_d = data_rel_q;
    off_d      = off_q;
    size_d     = size_q;

    if (take) begin
      pos_d    = pos_q + wavhfx_pkg::pos_t'(1);
      window_d = win;

      if (pos_q < wavhfx_pkg::pos_t'(4) &&
          byte_i != wavhfx_pkg::mark_byte(wavhfx_pkg::RiffMark, pos_q[1:0])) begin
        marker_d = 1'b0;
      end
      if (pos_q >= wavhfx_pkg::pos_t'(8) && pos_q < wavhfx_pkg::pos_t'(12) &&
          byte_i != wavhfx_pkg::mark_byte(wavhfx_pkg::WaveMark, pos_q[1:0])) begin
        marker_d = 1'b0;
      end

      if (fmt_rel_q != 5'd0 && fmt_rel_q != FmtSpan) begin
        fmt_rel_d = fmt_rel_q + 5'd1;
        case (fmt_rel_q)
          RelCh0:   ch_d[7:0]     = byte_i;
          RelCh1:   ch_d[15:8]    = byte_i;
          RelRate0: rate_d[7:0]   = byte_i;
          RelRate1: rate_d[15:8]  = byte_i;
          RelRate2: rate_d[23:16] = byte_i;
          RelRate3: rate_d[31:24] = byte_i;
          RelBits0: bits_d[7:0]   = byte_i;
          RelBits1: bits_d[15:8]  = byte_i;
          default: ;
        endcase
      end

      if (data_rel_q != 4'd0 && data_rel_q != DataDone) begin
        data_rel_d = data_rel_q + 4'd1;
        case (data_rel_q)
          RelSize0: size_d[7:0]   = byte_i;
          RelSize1: size_d[15:8]  = byte_i;
          RelSize2: size_d[23:16] = byte_i;
          RelSize3: size_d[31:24] = byte_i;
          default: ;
        endcase
      end

      // Tags count only from byte 12 on, so the window ends at byte 15 or later.
      if (pos_q >= wavhfx_pkg::pos_t'(15)) begin
        if (fmt_rel_q == 5'd0 && win == wavhfx_pkg::TagFmt) begin
          fmt_rel_d = FmtFirst;
        end
        if (data_rel_q == 4'd0 && win == wavhfx_pkg::TagData) begin
          data_rel_d = DataFirst;
          off_d      = 32'(pos_q) + 32'd5;
        end
      end
    end

    if (clear_i) begin
      pos_d      = '0;
      window_d   = '0;
      marker_d   = 1'b1;
      fmt_rel_d  = '0;
      ch_d       = '0;
      rate_d     = '0;
      bits_d     = '0;
      data_rel_d = '0;
      off_d      = '0;
      size_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      window_q   <= '0;
      marker_q   <= 1'b1;
      fmt_rel_q  <= '0;
      ch_q       <= '0;
      rate_q     <= '0;
      bits_q     <= '0;
      data_rel_q <= '0;
      off_q      <= '0;
      size_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      window_q   <= window_d;
      marker_q   <= marker_d;
      fmt_rel_q  <= fmt_rel_d;
      ch_q       <= ch_d;
      rate_q     <= rate_d;
      bits_q     <= bits_d;
      data_rel_q <= data_rel_d;
      off_q      <= off_d;
      size_q     <= size_d;
    end
  end

  logic ok, taken, confirmed;

  assign ok        = marker_q && (pos_q >= wavhfx_pkg::pos_t'(12));
  assign taken     = ok && (fmt_rel_q == FmtSpan);
  assign confirmed = ok && (data_rel_q == DataDone);

  always_comb begin
    sum_o.ok    = ok;
    sum_o.taken = taken;
    sum_o.ch    = taken ? ch_q   : wavhfx_pkg::DefChannels;
    sum_o.rate  = taken ? rate_q : wavhfx_pkg::DefRate;
    sum_o.bits  = taken ? bits_q : wavhfx_pkg::DefBits;
    sum_o.off   = confirmed ? off_q  : 32'd0;
    sum_o.size  = confirmed ? size_q : 32'd0;
  end

endmodule

// ===== hw/rtl/wavhfx_mul.sv =====
module wavhfx_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic        done_o,
  output logic [31:0] product_o
);

  localparam logic [4:0] Steps = 5'd16;

  logic [31:0] mcand_q;
  logic [15:0] mplier_q;
  logic [31:0] acc_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= Steps;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One multiplier bit per cycle, LSB first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= 32'(a_i);
      mplier_q <= b_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[30:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[15:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== hw/rtl/wavhfx_div.sv =====
module wavhfx_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wavhfx_pkg::QuoW-1:0]       dividend_i,
  input  logic [wavhfx_pkg::RateW-1:0]      divisor_i,
  input  logic [5:0]                        steps_i,
  output logic                              done_o,
  output logic [wavhfx_pkg::QuoW-1:0]       quotient_o
);

  // The dividend sits left-aligned; after steps_i shifts the quotient is in the low bits.
  logic [wavhfx_pkg::QuoW-1:0]  work_q;
  logic [wavhfx_pkg::RateW-1:0] rem_q;
  logic [wavhfx_pkg::RateW-1:0] dvs_q;
  logic [5:0]                   cnt_q;
  logic                         busy_q;
  logic                         done_q;

  logic [wavhfx_pkg::RateW:0]   trial;
  logic [wavhfx_pkg::RateW:0]   diff;
  logic                         fits;

  assign trial = {rem_q, work_q[wavhfx_pkg::QuoW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= steps_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[wavhfx_pkg::RateW-1:0] : trial[wavhfx_pkg::RateW-1:0];
      work_q <= {work_q[wavhfx_pkg::QuoW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

// ===== hw/rtl/wav_header_field_extractor_unit.sv =====
// WAV header field extractor. Stream a file in one byte per cycle on the
// input channel, with last_byte set on the final byte; one result follows.
// While bytes stream, in_ready_o stays high and each byte is a single-cycle
// transfer. After the last byte the unit stops taking input: it freezes the
// header fields, then, when the header is valid and rate, channels, bit depth
// and data size are all nonzero, runs a bit-serial 16-step multiply (bits x
// channels) and two passes of a shared bit-serial restoring divider, 35 steps
// for the sample count and 51 steps for the Q.16 duration. The multiplier
// takes one multiplier bit and the divider one quotient bit per cycle.
// Otherwise the unit goes from freezing the fields straight to its done
// state. The result sits in an output register, so the next file can stream
// in while it waits to be taken.
module wav_header_field_extractor_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wavhfx_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wavhfx_pkg::out_t  out_data_o
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_FINISH    = 6'b000010,
    S_MUL       = 6'b000100,
    S_DIV_TOTAL = 6'b001000,
    S_DIV_DUR   = 6'b010000,
    S_DONE      = 6'b100000
  } state_e;

  localparam logic [5:0] TotalSteps = 6'(wavhfx_pkg::TotalW);
  localparam logic [5:0] DurSteps   = 6'(wavhfx_pkg::QuoW);

  state_e state_q, state_d;

  wavhfx_pkg::scan_sum_t scan_sum;
  wavhfx_pkg::scan_sum_t sum_q;
  logic [wavhfx_pkg::TotalW-1:0] total_q;
  logic [wavhfx_pkg::QuoW-1:0]   dur_q;
  wavhfx_pkg::out_t              out_q;
  logic                          out_valid_q;

  logic in_take;
  logic compute;
  logic out_load;

  logic        mul_start, mul_done;
  logic [31:0] mul_product;

  logic                            div_start, div_done;
  logic [wavhfx_pkg::QuoW-1:0]     div_dividend, div_quotient;
  logic [wavhfx_pkg::RateW-1:0]    div_divisor;
  logic [5:0]                      div_steps;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_take    = in_valid_i && in_ready_o;

  wavhfx_scanner u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (in_take),
    .clear_i (state_q == S_FINISH),
    .byte_i  (in_data_i.byte_value),
    .sum_o   (scan_sum)
  );

  assign compute = scan_sum.ok && (scan_sum.rate != 32'd0) && (scan_sum.ch != 16'd0) &&
                   (scan_sum.bits != 16'd0) && (scan_sum.size != 32'd0);

  assign mul_start = (state_q == S_FINISH) && compute;

  wavhfx_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (scan_sum.bits),
    .b_i       (scan_sum.ch),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  // First pass: size*8 / (bits*channels). Second pass: (total << 16) / rate.
  always_comb begin
    if (state_q == S_MUL) begin
      div_start    = mul_done;
      div_dividend = {sum_q.size, 3'b000, 16'h0000};
      div_divisor  = mul_product;
      div_steps    = TotalSteps;
    end else begin
      div_start    = (state_q == S_DIV_TOTAL) && div_done;
      div_dividend = {div_quotient[wavhfx_pkg::TotalW-1:0], 16'h0000};
      div_divisor  = sum_q.rate;
      div_steps    = DurSteps;
    end
  end

  wavhfx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_take && in_data_i.last_byte) state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = compute ? S_MUL : S_DONE;
      end
      S_MUL: begin
        if (mul_done) state_d = S_DIV_TOTAL;
      end
      S_DIV_TOTAL: begin
        if (div_done) state_d = S_DIV_DUR;
      end
      S_DIV_DUR: begin
        if (div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH) begin
      sum_q   <= scan_sum;
      total_q <= '0;
      dur_q   <= '0;
    end
    if ((state_q == S_DIV_TOTAL) && div_done) begin
      total_q <= div_quotient[wavhfx_pkg::TotalW-1:0];
    end
    if ((state_q == S_DIV_DUR) && div_done) begin
      dur_q <= div_quotient;
    end
    if (out_load) begin
      out_q.header_ok       <= sum_q.ok;
      out_q.format_taken    <= sum_q.taken;
      out_q.channel_count   <= sum_q.ch;
      out_q.sample_rate     <= sum_q.rate;
      out_q.bits_per_sample <= sum_q.bits;
      out_q.data_offset     <= sum_q.off;
      out_q.data_size       <= sum_q.size;
      out_q.total_samples   <= total_q;
      out_q.duration_q16    <= dur_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/wavhfx_checker.sv =====
module wavhfx_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input wavhfx_pkg::in_t   in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input wavhfx_pkg::out_t  out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // Stop taking bytes once the last byte of a file is transferred.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_byte |=> !in_ready_o)
    else $error("byte taken right after the last byte");

  a_bad_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.header_ok |->
      !out_data_o.format_taken && out_data_o.data_offset == 32'd0 &&
      out_data_o.data_size == 32'd0 && out_data_o.total_samples == '0 &&
      out_data_o.duration_q16 == '0)
    else $error("bad header with nonzero fields");

  a_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.format_taken |->
      out_data_o.channel_count == wavhfx_pkg::DefChannels &&
      out_data_o.sample_rate == wavhfx_pkg::DefRate &&
      out_data_o.bits_per_sample == wavhfx_pkg::DefBits)
    else $error("format defaults not applied");

  a_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.total_samples == '0 || out_data_o.data_size == 32'd0) |->
      out_data_o.duration_q16 == '0)
    else $error("duration without samples");

endmodule

bind wav_header_field_extractor_unit wavhfx_checker u_checker (.*);
